>>> rtl/b64enc_pkg.sv
// b64enc_pkg: shared types, constants and the character lookup of the Base64 encoder.
// No dependencies. Used by every file under rtl/ except b64enc_ifs.
package b64enc_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharDigit0 = 8'h30;  // '0'
  localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
  localparam logic [7:0] PadChar    = 8'h3D;  // '='

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Pending byte count in the front end.
  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;

  // Position of a character inside its four-character group.
  localparam logic [1:0] CharFirst  = 2'd0;
  localparam logic [1:0] CharSecond = 2'd1;
  localparam logic [1:0] CharThird  = 2'd2;
  localparam logic [1:0] CharFourth = 2'd3;

  // One closed group handed from front to back.
  typedef struct packed {
    logic [23:0] bits;     // first byte in 23:16
    logic [1:0]  nbytes;   // 1..3 real bytes
    logic        last;     // group ends the message
  } group_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic pop;
    logic valid;
  } pop_ctl_t;

  // Six-bit value to its character of the standard alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] wide;
    wide = {2'b00, six};
    case (six) inside
      [6'd0:6'd25]:  return 8'(CharUpperA + wide);
      [6'd26:6'd51]: return 8'(CharLowerA + wide - 8'd26);
      [6'd52:6'd61]: return 8'(CharDigit0 + wide - 8'd52);
      6'd62:         return CharPlus;
      default:       return CharSlash;
    endcase
  endfunction

endpackage

>>> rtl/b64enc_ifs.sv
// b64enc_ifs: valid/ready channel interfaces for raw bytes and encoded characters.
// No dependencies.
interface b64enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

>>> rtl/b64enc_queue.sv
// b64enc_queue: short FIFO of closed byte groups between front and back.
// Depends on b64enc_pkg.
module b64enc_queue
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  group_t    push_group,
  input  logic      push,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output group_t    pop_group
);

  group_t                store [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;

  logic do_push;
  logic do_pop;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign valid     = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign pop_group = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("group pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid)) else $error("group popped from empty queue");

endmodule

>>> rtl/b64enc_front.sv
// b64enc_front: takes raw bytes, holds up to two pending bytes, closes groups.
// Depends on b64enc_pkg and b64enc_ifs.
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  b64enc_byte_if.sink raw,
  input  push_ctl_t  q_ctl_in,   // only .full is used
  output logic       push,
  output group_t     push_group
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [15:0] pending_bytes_next;
  logic [1:0]  pending_count_next;
  logic        accept;

  assign raw.ready = !q_ctl_in.full;
  assign accept    = raw.valid && raw.ready;

  always_comb begin
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    push               = 1'b0;
    push_group.bits    = {raw.data_byte, 16'h0000};
    push_group.nbytes  = 2'd1;
    push_group.last    = raw.end_of_message;
    case (pending_count)
      CountOne: begin
        push_group.bits   = {pending_bytes[15:8], raw.data_byte, 8'h00};
        push_group.nbytes = 2'd2;
        if (accept) begin
          if (raw.end_of_message) begin
            push               = 1'b1;
            pending_bytes_next = '0;
            pending_count_next = CountNone;
          end else begin
            pending_bytes_next = {pending_bytes[15:8], raw.data_byte};
            pending_count_next = CountTwo;
          end
        end
      end
      CountTwo: begin
        push_group.bits   = {pending_bytes, raw.data_byte};
        push_group.nbytes = 2'd3;
        if (accept) begin
          push               = 1'b1;
          pending_bytes_next = '0;
          pending_count_next = CountNone;
        end
      end
      default: begin  // no pending bytes
        if (accept) begin
          if (raw.end_of_message) begin
            push               = 1'b1;
            pending_bytes_next = '0;
            pending_count_next = CountNone;
          end else begin
            pending_bytes_next = {raw.data_byte, 8'h00};
            pending_count_next = CountOne;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= CountNone;
    end else begin
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && raw.end_of_message) |=> (pending_count == CountNone))
    else $error("pending bytes left after end of message");
  a_push_closes: assert property (@(posedge clk) disable iff (rst)
    push |-> (raw.end_of_message || push_group.nbytes == 2'd3))
    else $error("open group pushed");

endmodule

>>> rtl/b64enc_back.sv
// b64enc_back: turns one queued group into four characters, one per cycle while chars.ready allows.
// Depends on b64enc_pkg and b64enc_ifs.
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pop_ctl_t    q_ctl_in,   // only .valid is used
  input  group_t      pop_group,
  output logic        pop,
  b64enc_char_if.source chars
);

  group_t      cur;
  logic        busy;
  logic [1:0]  idx;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  logic        adv;
  logic        emit;
  logic        done;
  logic [5:0]  six;
  logic        pad;
  logic [7:0]  char_next;

  assign adv  = !out_valid || chars.ready;
  assign emit = adv && busy;
  assign done = emit && (idx == CharFourth);
  assign pop  = q_ctl_in.valid && (!busy || done);

  always_comb begin
    case (idx)
      CharFirst:  six = cur.bits[23:18];
      CharSecond: six = cur.bits[17:12];
      CharThird:  six = cur.bits[11:6];
      default:    six = cur.bits[5:0];
    endcase
    pad = ((idx == CharThird) && (cur.nbytes < 2'd2)) ||
          ((idx == CharFourth) && (cur.nbytes < 2'd3));
    char_next = pad ? PadChar : b64_char(six);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_group;
    end
    if (emit) begin
      out_char <= char_next;
      out_last <= cur.last && (idx == CharFourth);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= CharFirst;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= CharFirst;
      end else if (done) begin
        busy <= 1'b0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  assign chars.valid     = out_valid;
  assign chars.code_char = out_char;
  assign chars.last_char = out_last;

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (busy && idx == CharFirst))
    else $error("group load did not restart character count");
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (emit && cur.last && idx == CharFourth) |=> (out_valid && out_last))
    else $error("final character not flagged");

endmodule

>>> rtl/base64_encoder.sv
// base64_encoder: top level of the streaming Base64 (standard alphabet) encoder.
// Depends on b64enc_pkg, b64enc_ifs, b64enc_front, b64enc_queue, b64enc_back.
//
//   channel | dir | payload                         | word
//   --------+-----+---------------------------------+--------------------------
//   raw     | in  | data_byte[7:0], end_of_message  | one message byte
//   encoded | out | code_char[7:0], last_char       | one ASCII character or '='
//
// Rate: the back end emits one character per cycle while encoded.ready allows,
//   four per group, also for a group closed early by end_of_message.
// Path: a byte that closes a group is written into the group queue, loaded
//   into the back end's group register, then its first character is registered.
// Reset: rst synchronous, active high; clears pending bytes, queue and output.
// Stalls: a 2-deep group queue parts front and back; raw.ready drops only
//   when that queue is full. encoded.ready low holds the output register.
module base64_encoder
  import b64enc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  b64enc_byte_if.sink     raw,
  b64enc_char_if.source   encoded
);

  // Front end -> queue
  group_t    push_group;
  logic      push;
  push_ctl_t push_ctl;

  // Queue -> back end
  group_t    pop_group;
  logic      pop;
  pop_ctl_t  pop_ctl;

  // Front end: collects bytes and closes groups of one to three bytes.
  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .q_ctl_in   (push_ctl),
    .push       (push),
    .push_group (push_group)
  );

  assign push_ctl.push = push;
  assign pop_ctl.pop   = pop;

  // Group queue: lets byte intake run ahead while characters drain.
  b64enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_group (push_group),
    .push       (push_ctl.push),
    .full       (push_ctl.full),
    .pop        (pop_ctl.pop),
    .valid      (pop_ctl.valid),
    .pop_group  (pop_group)
  );

  // Back end: maps each group to four characters with padding.
  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_ctl_in   (pop_ctl),
    .pop_group  (pop_group),
    .pop        (pop),
    .chars      (encoded)
  );

endmodule

>>> verif/b64enc_tb_pkg.sv
`timescale 1ns / 1ps
// b64enc_tb_pkg: expected-character tracker for the Base64 encoder testbench.
// Depends on b64enc_pkg for the pad character and the pending-count codes.
package b64enc_tb_pkg;
  import b64enc_pkg::*;

  // Standard alphabet, index 0 in the top byte.
  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  class b64_char_checker;
    logic [15:0] held_bytes;   // first held byte in 15:8
    logic [1:0]  held_count;
    enc_char_t   exp_chars[$];
    int          errors;

    function new();
      held_bytes = '0;
      held_count = CountNone;
      errors     = 0;
    endfunction

    function logic [7:0] sym(logic [5:0] six);
      return B64Alphabet[8*(63 - six) +: 8];
    endfunction

    // Four characters for a group of n real bytes packed in 23:0.
    function void encode_group(logic [23:0] grp, int n, logic last);
      exp_chars.push_back(enc_char_t'{sym(grp[23:18]), 1'b0});
      exp_chars.push_back(enc_char_t'{sym(grp[17:12]), 1'b0});
      exp_chars.push_back(enc_char_t'{(n >= 2) ? sym(grp[11:6]) : PadChar, 1'b0});
      exp_chars.push_back(enc_char_t'{(n >= 3) ? sym(grp[5:0]) : PadChar, last});
    endfunction

    // Called for every accepted raw word.
    function void take_byte(logic [7:0] b, logic eom);
      logic [1:0] cnt;
      cnt = (held_count > CountTwo) ? CountNone : held_count;
      case (cnt)
        CountNone: begin
          if (eom) begin
            encode_group({b, 16'h0000}, 1, 1'b1);
          end else begin
            held_bytes = {b, 8'h00};
            held_count = CountOne;
          end
        end
        CountOne: begin
          if (eom) begin
            encode_group({held_bytes[15:8], b, 8'h00}, 2, 1'b1);
            held_bytes = '0;
            held_count = CountNone;
          end else begin
            held_bytes = {held_bytes[15:8], b};
            held_count = CountTwo;
          end
        end
        default: begin
          encode_group({held_bytes, b}, 3, eom);
          held_bytes = '0;
          held_count = CountNone;
        end
      endcase
    endfunction

    // Called for every accepted encoded word.
    function void check_char(logic [7:0] code, logic last);
      enc_char_t e;
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected char %h last %b", $time, code, last);
        errors++;
        return;
      end
      e = exp_chars.pop_front();
      if (code !== e.code) begin
        $display("%0t: code_char expected %h got %h", $time, e.code, code);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_char expected %b got %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return exp_chars.size();
    endfunction
  endclass

endpackage

>>> verif/base64_encoder_tb.sv
`timescale 1ns / 1ps
// base64_encoder_tb: directed and random byte streams through base64_encoder,
// each encoded word checked against a predicted character stream.
// Depends on b64enc_pkg, b64enc_ifs, b64enc_tb_pkg and the RTL of base64_encoder.
module base64_encoder_tb;
  import b64enc_tb_pkg::*;

  localparam int RandomItems = 305;
  localparam int HoldCycles  = 80;     // receiver hold-off to fill the group queue
  localparam int WatchLimit  = 2000;   // cycles without any handshake
  localparam int DrainCycles = 12;     // extra wait after the last expected character

  // Directed words: {end_of_message, data_byte}.
  localparam logic [8:0] Directed [22] = '{
    9'h100,                                  // single zero byte, two pads
    9'h1FF,                                  // single 0xFF byte
    9'h0FB, 9'h1FF,                          // two bytes hitting '+' and '/', one pad
    9'h000, 9'h0FF, 9'h180,                  // flag on a full group, no pad
    9'h0FF, 9'h0FF, 9'h0FF,                  // full group without flag
    9'h04D, 9'h061, 9'h16E,
    9'h012, 9'h034, 9'h056, 9'h178,          // four bytes, group then one pad pair
    9'h0A5, 9'h05A, 9'h001, 9'h0FE, 9'h17F   // five bytes
  };

  logic clk;
  logic rst;

  b64enc_byte_if raw_if ();
  b64enc_char_if enc_if ();

  base64_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .encoded (enc_if)
  );

  b64_char_checker board = new();

  // idle rates in percent, changed per phase by the stimulus process
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit hold_req      = 1'b0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitors: both channels sampled at the edge, before any update of that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (raw_if.valid && raw_if.ready)
        board.take_byte(raw_if.data_byte, raw_if.end_of_message);
      if (enc_if.valid && enc_if.ready) begin
        if (board.outstanding() == 0) begin
          // a character nobody asked for ends the run at once
          board.check_char(enc_if.code_char, enc_if.last_char);
          $display("** base64_encoder: FAILED **");
          $finish;
        end else begin
          board.check_char(enc_if.code_char, enc_if.last_char);
        end
      end
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (raw_if.valid && raw_if.ready) || (enc_if.valid && enc_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired, no handshake for %0d cycles", $time, WatchLimit);
      $display("** base64_encoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off counted here when requested.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    enc_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        enc_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        enc_if.ready <= 1'b0;
      end else begin
        enc_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the word until raw.ready takes it.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk);
    end
    raw_if.valid          <= 1'b1;
    raw_if.data_byte      <= b;
    raw_if.end_of_message <= eom;
    @(posedge clk);
    while (!raw_if.ready) @(posedge clk);
  endtask

  // One message of random bytes, flag on the last one.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int len;
    bit hold_done;
    sent      = 0;
    hold_done = 1'b0;

    rst                   <= 1'b1;
    raw_if.valid          <= 1'b0;
    raw_if.data_byte      <= '0;
    raw_if.end_of_message <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, pad cases, flagged and unflagged full groups
    src_idle_pct  = 22;
    sink_idle_pct = 22;
    foreach (Directed[i])
      send_byte(Directed[i][7:0], Directed[i][8]);

    // random messages; first stretch runs back to back on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (sent < RandomItems) begin
      if (sent >= 60) begin
        src_idle_pct  = 22;
        sink_idle_pct = 22;
      end
      // one receiver hold-off while the sender keeps pushing
      if (!hold_done && sent >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // mostly short messages to hit every group phase, some longer
      len = ($urandom_range(4) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
      send_message(len);
      sent += len;
    end
    raw_if.valid <= 1'b0;

    // watchdog bounds this wait
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("** base64_encoder: PASSED **");
    end else begin
      $display("** base64_encoder: FAILED **");
    end
    $finish;
  end

endmodule
